/* hdl/cbmd_pkg.sv */
// Package for the chained byte-mix block decryptor.
// Holds the sequencer state type, the control struct, the mode code and the key table.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package cbmd_pkg;

    localparam int BlockW = 64;
    localparam int ModeW  = 2;

    // Key mode that runs one round with the first row of key set C
    localparam logic [ModeW-1:0] MODE_ONE_ROUND = 2'd3;

    // Key row selectors
    localparam logic [1:0] ROW_PRE   = 2'd0;
    localparam logic [1:0] ROW_MID   = 2'd1;
    localparam logic [1:0] ROW_FINAL = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ROUND1,
        ST_ROUND2,
        ST_OUT
    } cbmd_state_t;

    // Sequencer to datapath controls
    typedef struct packed {
        logic busy;      // not taking input
        logic load;      // input transfer this cycle
        logic round1;    // first round on shared unit
        logic round2;    // second round on shared unit
        logic out_valid; // result held for transfer
    } cbmd_ctrl_t;

    // Key table: set selected by mode (mode 3 uses set C), row 0..2
    function automatic logic [BlockW-1:0] key_row(input logic [ModeW-1:0] mode,
                                                  input logic [1:0] row);
        logic [BlockW-1:0] k;
        k = '0;
        case (mode)
            2'd0:
                case (row)
                    ROW_PRE:   k = 64'h971E24A09A00102B;
                    ROW_MID:   k = 64'h91EFD77ACD11AFAF;
                    default:   k = 64'h8D265DBBE0C61B2B;
                endcase
            2'd1:
                case (row)
                    ROW_PRE:   k = 64'h2D865662D7FDCAA4;
                    ROW_MID:   k = 64'hB32460262481DBC2;
                    default:   k = 64'h57B1746FA7529921;
                endcase
            default:
                case (row)
                    ROW_PRE:   k = 64'hEDF09C90441A5A03;
                    ROW_MID:   k = 64'hAB07C199232432C7;
                    default:   k = 64'h5F32A597AD980F8F;
                endcase
        endcase
        return k;
    endfunction

endpackage

`default_nettype wire

/* hdl/cbmd_round.sv */
// Shared mixing round: key XOR, then byte mix of the lower four bytes from the upper four.
// Depends on cbmd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cbmd_round (
    input  wire logic [cbmd_pkg::BlockW-1:0] blk,
    input  wire logic [cbmd_pkg::BlockW-1:0] key,
    output logic      [cbmd_pkg::BlockW-1:0] mixed
);
    import cbmd_pkg::*;

    logic [BlockW-1:0] v;
    logic [7:0] v0, v1, v2, v3;
    logic [7:0] a, b, c, d, e, f, g;

    // Byte 0 sits in the top byte
    assign v  = blk ^ key;
    assign v0 = v[63:56];
    assign v1 = v[55:48];
    assign v2 = v[47:40];
    assign v3 = v[39:32];

    // Mod-256 mix arithmetic
    always_comb
    begin
        a = 8'(16'(v0) * 16'd63);
        b = a + v3;
        c = 8'(16'(v1) * 16'd17);
        d = c + v2;
        e = d + b;
        f = 8'(16'(e) * 16'(v3));
        g = f + b + 8'd51;
    end

    assign mixed = {v[63:32],
                    v[31:24] ^ (b ^ d),
                    v[23:16] ^ d,
                    v[15:8]  ^ (g ^ e),
                    v[7:0]   ^ g};

endmodule

`default_nettype wire

/* hdl/cbmd_ctrl.sv */
// Sequencer for the decryptor: idle, one or two rounds, then result hold.
// Depends on cbmd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cbmd_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    input  wire logic                out_stall,
    input  wire logic                one_round,
    output cbmd_pkg::cbmd_ctrl_t     ctrl
);
    import cbmd_pkg::*;

    cbmd_state_t state_reg, state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (in_valid)
                    state_next = ST_ROUND1;
            ST_ROUND1:
                state_next = one_round ? ST_OUT : ST_ROUND2;
            ST_ROUND2:
                state_next = ST_OUT;
            ST_OUT:
                if (!out_stall)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Outputs
    always_comb
    begin
        ctrl = '0;
        unique case (state_reg)
            ST_IDLE:
                ctrl.load = in_valid;
            ST_ROUND1:
            begin
                ctrl.busy   = 1'b1;
                ctrl.round1 = 1'b1;
            end
            ST_ROUND2:
            begin
                ctrl.busy   = 1'b1;
                ctrl.round2 = 1'b1;
            end
            ST_OUT:
            begin
                ctrl.busy      = 1'b1;
                ctrl.out_valid = 1'b1;
            end
            default:
                ctrl.busy = 1'b1;
        endcase
    end

endmodule

`default_nettype wire

/* hdl/chained_byte_mix_block_decrypt.sv */
// Top level of the chained byte-mix block decryptor: datapath registers and chaining.
// Depends on cbmd_pkg, cbmd_round and cbmd_ctrl.
//
//  channel | handshake             | payload
//  --------+-----------------------+-------------------------------
//  input   | in_valid / in_stall   | cipher_block[63:0], restart
//  output  | out_valid / out_stall | plain_block[63:0]
//  config  | key_mode_wr           | key_mode[1:0]
//
// An item passes through input transfer, round 1, round 2 and result transfer before the next
// input transfer in key modes 0-2, and skips round 2 in mode 3: one mixing unit
// is reused for each round, one round per cycle, and the result register holds one block.
// A stalled result holds the block and keeps in_stall high until its transfer.
// rst_n clears the sequencer, the key mode and the chaining block to zero.
`timescale 1ns / 1ps
`default_nettype none

module chained_byte_mix_block_decrypt (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_stall,
    input  wire logic [cbmd_pkg::BlockW-1:0] cipher_block,
    input  wire logic                        restart,
    output logic                             out_valid,
    input  wire logic                        out_stall,
    output logic      [cbmd_pkg::BlockW-1:0] plain_block,
    input  wire logic                        key_mode_wr,
    input  wire logic [cbmd_pkg::ModeW-1:0]  key_mode
);
    import cbmd_pkg::*;

    cbmd_ctrl_t ctrl;

    logic [ModeW-1:0]  mode_reg;
    logic [BlockW-1:0] prev_reg;
    logic [BlockW-1:0] chain_reg;
    logic [BlockW-1:0] work_reg, work_next;
    logic [BlockW-1:0] result_reg, result_next;
    logic [BlockW-1:0] round_key;
    logic [BlockW-1:0] mixed;
    logic              one_round;

    assign one_round = (mode_reg == MODE_ONE_ROUND);

    // Sequencer
    cbmd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .out_stall (out_stall),
        .one_round (one_round),
        .ctrl      (ctrl)
    );

    // Shared round unit, key row picked by round
    assign round_key = key_row(mode_reg, ctrl.round1 ? ROW_PRE : ROW_MID);

    cbmd_round u_round (
        .blk   (work_reg),
        .key   (round_key),
        .mixed (mixed)
    );

    // Control-side registers: key mode and chaining block
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= '0;
            prev_reg <= '0;
        end
        else
        begin
            if (key_mode_wr)
                mode_reg <= key_mode;
            if (ctrl.load)
                prev_reg <= cipher_block;
        end
    end

    // Work and result next values
    always_comb
    begin
        work_next   = work_reg;
        result_next = result_reg;
        if (ctrl.load)
            work_next = cipher_block;
        else if (ctrl.round1)
        begin
            work_next   = {mixed[31:0], mixed[63:32]};
            result_next = {mixed[31:0], mixed[63:32]} ^ chain_reg;
        end
        else if (ctrl.round2)
            result_next = mixed ^ key_row(mode_reg, ROW_FINAL) ^ chain_reg;
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        work_reg   <= work_next;
        result_reg <= result_next;
        if (ctrl.load)
            chain_reg <= restart ? '0 : prev_reg;
    end

    assign in_stall    = ctrl.busy;
    assign out_valid   = ctrl.out_valid;
    assign plain_block = result_reg;

    // Assertions
    a_load_starts: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.load |=> ctrl.round1)
        else $error("input transfer not followed by round 1");

    a_two_rounds: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.round1 && !one_round) |=> ctrl.round2)
        else $error("two-round mode skipped round 2");

    a_one_round: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.round1 && one_round) |=> (out_valid && !ctrl.round2))
        else $error("one-round mode ran a second round");

    a_phases: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({ctrl.load, ctrl.round1, ctrl.round2, ctrl.out_valid}))
        else $error("sequencer phases overlap");

endmodule

`default_nettype wire
